FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by the top-level design file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/bedw_pkg.sv
// ---------------------------------------------------------------------------
// bedw_pkg
// shared types and constants of the binary erode / dilate window block
// ---------------------------------------------------------------------------
`default_nettype none

package bedw_pkg;

    localparam int PIXEL_W    = 8;
    localparam int KERNEL_W   = 4;
    localparam int IMG_W_W    = 12;
    localparam int IMG_H_W    = 13;
    localparam int CFG_DATA_W = 13;

    localparam logic [PIXEL_W-1:0] PIX_LOW  = 8'd0;
    localparam logic [PIXEL_W-1:0] PIX_HIGH = 8'd255;

    localparam logic                  DILATE_RESET = 1'b0;
    localparam logic [KERNEL_W-1:0]   KERNEL_RESET = 4'd3;
    localparam logic [IMG_W_W-1:0]    WIDTH_RESET  = 12'd640;
    localparam logic [IMG_H_W-1:0]    HEIGHT_RESET = 13'd480;

    typedef enum logic [1:0] {
        REG_DILATE_MODE  = 2'd0,
        REG_KERNEL_SIZE  = 2'd1,
        REG_IMAGE_WIDTH  = 2'd2,
        REG_IMAGE_HEIGHT = 2'd3
    } bedw_reg_t;

endpackage

`default_nettype wire

FILE: design/bedw_if.sv
// ---------------------------------------------------------------------------
// bedw_if
// valid / ready channels: pixel input, result output, register writes
// ---------------------------------------------------------------------------
`default_nettype none

interface bedw_pix_if;
    logic                             valid;
    logic                             ready;
    logic [bedw_pkg::PIXEL_W-1:0]     pixel_value;
    logic                             drain;

    modport source (output valid, output pixel_value, output drain, input ready);
    modport sink   (input valid, input pixel_value, input drain, output ready);
endinterface

interface bedw_res_if;
    logic                             valid;
    logic                             ready;
    logic [bedw_pkg::PIXEL_W-1:0]     result_value;
    logic                             frame_end;

    modport source (output valid, output result_value, output frame_end, input ready);
    modport sink   (input valid, input result_value, input frame_end, output ready);
endinterface

interface bedw_cfg_if;
    logic                             valid;
    logic                             ready;
    bedw_pkg::bedw_reg_t              index;
    logic [bedw_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/bedw_ram.sv
// ---------------------------------------------------------------------------
// bedw_ram
// simple dual-port ram, one write port, one read port with registered data
// ---------------------------------------------------------------------------
`default_nettype none

module bedw_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 2048
) (
    input  wire                       clk,
    input  wire                       we,
    input  wire [$clog2(DEPTH)-1:0]   waddr,
    input  wire [WIDTH-1:0]           wdata,
    input  wire                       re,
    input  wire [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: design/bedw_line_store.sv
// ---------------------------------------------------------------------------
// bedw_line_store
// one ram bank per buffered row; writes go to one bank, reads hit all banks
// ---------------------------------------------------------------------------
`default_nettype none

module bedw_line_store #(
    parameter int BANKS = 30,
    parameter int DEPTH = 2048,
    parameter int WIDTH = 4
) (
    input  wire                             clk,
    input  wire                             we,
    input  wire [$clog2(BANKS)-1:0]         wbank,
    input  wire [$clog2(DEPTH)-1:0]         waddr,
    input  wire [WIDTH-1:0]                 wdata,
    input  wire                             re,
    input  wire [$clog2(DEPTH)-1:0]         raddr,
    output logic [BANKS-1:0][WIDTH-1:0]     rdata
);

    localparam int SW = $clog2(BANKS);

    for (genvar b = 0; b < BANKS; b++)
    begin : g_bank
        logic bank_we;

        assign bank_we = we && (wbank == SW'(b));

        bedw_ram #(
            .WIDTH (WIDTH),
            .DEPTH (DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (bank_we),
            .waddr (waddr),
            .wdata (wdata),
            .re    (re),
            .raddr (raddr),
            .rdata (rdata[b])
        );
    end

endmodule

`default_nettype wire

FILE: design/bedw_window_or.sv
// ---------------------------------------------------------------------------
// bedw_window_or
// window hit test: per bank row mask and distance compare, then or-reduce
// ---------------------------------------------------------------------------
`default_nettype none

module bedw_window_or #(
    parameter int BANKS = 30,
    parameter int DW    = 4,
    parameter int HW    = 3
) (
    input  wire [BANKS-1:0][DW-1:0]     run_len,
    input  wire [$clog2(BANKS)-1:0]     slot,
    input  wire [DW-1:0]                span,
    input  wire [HW-1:0]                up,
    input  wire [HW-1:0]                dn,
    output logic                        hit
);

    localparam int SW = $clog2(BANKS);

    logic [SW:0]        rel [BANKS];
    logic [SW:0]        slot_e;
    logic [BANKS-1:0]   hit_bits;

    always_comb
    begin
        slot_e = (SW+1)'(slot);
        for (int b = 0; b < BANKS; b++)
        begin
            if ((SW+1)'(b) >= slot_e)
            begin
                rel[b] = (SW+1)'(b) - slot_e;
            end
            else
            begin
                rel[b] = (SW+1)'(b) + (SW+1)'(BANKS) - slot_e;
            end
            // rows below center up to dn, rows above center up to up
            hit_bits[b] = ((rel[b] <= (SW+1)'(dn))
                          || ((rel[b] + (SW+1)'(up)) >= (SW+1)'(BANKS)))
                          && (run_len[b] <= span);
        end
        hit = |hit_bits;
    end

endmodule

`default_nettype wire

FILE: design/binary_erode_dilate_window_top.sv
// ---------------------------------------------------------------------------
// binary_erode_dilate_window_top
// streaming square-window binary erosion / dilation with edge replication
// ---------------------------------------------------------------------------
// pix: one grey pixel per beat in raster order; drain beats carry no pixel
//   and push out results still owed after the last pixel of a frame
// res: one 0 / 255 pixel per beat, frame_end on the last pixel of the frame
// cfg: register writes (dilate_mode, kernel_size, image_width, image_height),
//   always ready; a write restarts the frame, input pauses in the cycle after it
// throughput: one beat per cycle on pix and res unless res.ready is low or a cfg
//   write pauses input; each row keeps, per pixel, the distance to the last
//   flagged pixel on its left, so one read of all row banks at one column answers a whole window
// pipeline: a released result moves through s1, then s2 with the line store
//   read, then into the output register; results trail the pixels by
//   half*width+half beats
// reset: counters clear, registers take 0 / 3 / 640 / 480, input pauses
//   while settle_reg is set; the line store needs no clearing pass
// stall: the output register holds while res.ready is low; two more result
//   beats are taken into the internal stages before pix.ready drops
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module binary_erode_dilate_window_top #(
    parameter int MAX_KERNEL = 15,
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input wire           clk,
    input wire           rst_n,
    bedw_pix_if.sink     pix,
    bedw_res_if.source   res,
    bedw_cfg_if.sink     cfg
);

    localparam int HALF_MAX = (MAX_KERNEL - 1) / 2;
    localparam int HW       = (HALF_MAX > 0) ? $clog2(HALF_MAX + 1) : 1;
    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int RW       = $clog2(MAX_HEIGHT);
    localparam int BANKS    = 2 * MAX_KERNEL;
    localparam int SW       = $clog2(BANKS);
    localparam int DW       = $clog2(MAX_KERNEL + 1);
    localparam int LW       = $clog2(HALF_MAX * MAX_WIDTH + HALF_MAX + 2);
    localparam int KODD     = (MAX_KERNEL % 2 == 1) ? MAX_KERNEL : MAX_KERNEL - 1;
    localparam int KW       = bedw_pkg::KERNEL_W + 1;
    localparam logic [DW-1:0] DIST_SAT = DW'(MAX_KERNEL);

    // configuration
    logic                              dilate_reg, dilate_next;
    logic [bedw_pkg::KERNEL_W-1:0]     ksize_reg, ksize_next;
    logic [bedw_pkg::IMG_W_W-1:0]      iwidth_reg, iwidth_next;
    logic [bedw_pkg::IMG_H_W-1:0]      iheight_reg, iheight_next;
    logic                              settle_reg;

    // derived geometry
    logic [CW-1:0]      wm1_reg, wm1_next;
    logic [RW-1:0]      hm1_reg, hm1_next;
    logic [HW-1:0]      half_reg, half_next;
    logic [LW-1:0]      lat_reg, lat_next;
    logic [KW-1:0]      k_odd, k_eff;
    logic [HW+CW-1:0]   lat_prod;

    // frame counters
    logic [CW-1:0]  in_col_reg, in_col_next;
    logic [RW-1:0]  in_row_reg, in_row_next;
    logic [SW-1:0]  in_slot_reg, in_slot_next;
    logic           in_done_reg, in_done_next;
    logic [DW-1:0]  dist_reg, dist_next;
    logic [CW-1:0]  out_col_reg, out_col_next;
    logic [RW-1:0]  out_row_reg, out_row_next;
    logic [SW-1:0]  out_slot_reg, out_slot_next;
    logic [LW-1:0]  d_reg, d_next;

    // pipeline
    logic           s1_valid_reg, s1_valid_next;
    logic [CW-1:0]  s1_raddr_reg;
    logic [DW-1:0]  s1_span_reg;
    logic [HW-1:0]  s1_up_reg, s1_dn_reg;
    logic [SW-1:0]  s1_slot_reg;
    logic           s1_last_reg;
    logic           s2_valid_reg, s2_valid_next;
    logic [DW-1:0]  s2_span_reg;
    logic [HW-1:0]  s2_up_reg, s2_dn_reg;
    logic [SW-1:0]  s2_slot_reg;
    logic           s2_last_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [bedw_pkg::PIXEL_W-1:0]   out_value_reg;
    logic                           out_last_reg;

    // control
    logic           cfg_acc, out_load, s1_move, in_ready, in_acc, pix_take, flag;
    logic           in_col_last, in_row_last, in_last, out_last, emit, clear;
    logic [DW-1:0]  flag_dist;
    logic [CW:0]    hi_sum;
    logic [CW-1:0]  win_hi, win_lo;
    logic [RW-1:0]  rows_left;
    logic [DW-1:0]  win_span;
    logic [HW-1:0]  win_up, win_dn;
    logic [BANKS-1:0][DW-1:0] bank_dist;
    logic           hit;

    assign cfg.ready    = 1'b1;
    assign pix.ready    = in_ready;
    assign res.valid    = out_valid_reg;
    assign res.result_value = out_value_reg;
    assign res.frame_end    = out_last_reg;

    // configuration and geometry
    always_comb
    begin
        dilate_next  = dilate_reg;
        ksize_next   = ksize_reg;
        iwidth_next  = iwidth_reg;
        iheight_next = iheight_reg;
        cfg_acc      = cfg.valid && cfg.ready;
        if (cfg_acc)
        begin
            unique case (cfg.index)
                bedw_pkg::REG_DILATE_MODE:  dilate_next  = cfg.data[0];
                bedw_pkg::REG_KERNEL_SIZE:  ksize_next   = cfg.data[bedw_pkg::KERNEL_W-1:0];
                bedw_pkg::REG_IMAGE_WIDTH:  iwidth_next  = cfg.data[bedw_pkg::IMG_W_W-1:0];
                bedw_pkg::REG_IMAGE_HEIGHT: iheight_next = cfg.data[bedw_pkg::IMG_H_W-1:0];
            endcase
        end

        k_odd = {1'b0, ksize_reg} | KW'(1);
        k_eff = (32'(k_odd) > MAX_KERNEL) ? KW'(KODD) : k_odd;
        half_next = HW'(k_eff >> 1);

        if (iwidth_reg == '0)
        begin
            wm1_next = '0;
        end
        else if (32'(iwidth_reg) > MAX_WIDTH)
        begin
            wm1_next = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            wm1_next = CW'(32'(iwidth_reg) - 1);
        end

        if (iheight_reg == '0)
        begin
            hm1_next = '0;
        end
        else if (32'(iheight_reg) > MAX_HEIGHT)
        begin
            hm1_next = RW'(MAX_HEIGHT - 1);
        end
        else
        begin
            hm1_next = RW'(32'(iheight_reg) - 1);
        end

        // half * width + half = half * (width - 1) + 2 * half
        lat_prod = (HW+CW)'(half_next) * (HW+CW)'(wm1_next);
        lat_next = LW'(lat_prod) + LW'(half_next) + LW'(half_next);
    end

    // handshake, counters and window geometry
    always_comb
    begin
        out_load = s2_valid_reg && (!out_valid_reg || res.ready);
        s1_move  = s1_valid_reg && (!s2_valid_reg || out_load);
        in_ready = (!s1_valid_reg || s1_move) && !settle_reg;
        in_acc   = pix.valid && in_ready;
        pix_take = in_acc && !in_done_reg && !pix.drain;
        flag     = dilate_reg ? (pix.pixel_value == bedw_pkg::PIX_HIGH)
                              : (pix.pixel_value == bedw_pkg::PIX_LOW);

        in_col_last = (in_col_reg == wm1_reg);
        in_row_last = (in_row_reg == hm1_reg);
        in_last     = in_col_last && in_row_last;
        out_last    = (out_col_reg == wm1_reg) && (out_row_reg == hm1_reg);

        if (pix_take)
        begin
            emit = (d_reg >= lat_reg) || in_last;
        end
        else
        begin
            emit = in_acc && in_done_reg && (d_reg != '0);
        end

        // distance written for the incoming pixel
        if (flag)
        begin
            flag_dist = '0;
        end
        else if ((in_col_reg == '0) || (dist_reg == DIST_SAT))
        begin
            flag_dist = DIST_SAT;
        end
        else
        begin
            flag_dist = dist_reg + 1'b1;
        end

        hi_sum   = (CW+1)'(out_col_reg) + (CW+1)'(half_reg);
        win_hi   = (hi_sum >= (CW+1)'(wm1_reg)) ? wm1_reg : CW'(hi_sum);
        win_lo   = (out_col_reg >= CW'(half_reg)) ? (out_col_reg - CW'(half_reg)) : '0;
        win_span = DW'(win_hi - win_lo);
        win_up   = (out_row_reg >= RW'(half_reg)) ? half_reg : HW'(out_row_reg);
        rows_left = hm1_reg - out_row_reg;
        win_dn   = (rows_left >= RW'(half_reg)) ? half_reg : HW'(rows_left);

        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_slot_next  = in_slot_reg;
        in_done_next  = in_done_reg;
        dist_next     = dist_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_slot_next = out_slot_reg;
        d_next        = d_reg;

        if (pix_take)
        begin
            dist_next = flag_dist;

            if (in_col_last)
            begin
                in_col_next = '0;
                if (in_row_last)
                begin
                    in_done_next = 1'b1;
                end
                else
                begin
                    in_row_next  = in_row_reg + 1'b1;
                    in_slot_next = (in_slot_reg == SW'(BANKS - 1)) ? '0 : in_slot_reg + 1'b1;
                end
            end
            else
            begin
                in_col_next = in_col_reg + 1'b1;
            end
        end

        if (emit)
        begin
            if (out_col_reg == wm1_reg)
            begin
                out_col_next  = '0;
                out_row_next  = out_row_reg + 1'b1;
                out_slot_next = (out_slot_reg == SW'(BANKS - 1)) ? '0 : out_slot_reg + 1'b1;
            end
            else
            begin
                out_col_next = out_col_reg + 1'b1;
            end
        end

        unique case ({pix_take, emit})
            2'b10:   d_next = d_reg + 1'b1;
            2'b01:   d_next = d_reg - 1'b1;
            default: d_next = d_reg;
        endcase

        clear = cfg_acc || (emit && out_last);
        if (clear)
        begin
            in_col_next   = '0;
            in_row_next   = '0;
            in_slot_next  = '0;
            in_done_next  = 1'b0;
            dist_next     = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            out_slot_next = '0;
            d_next        = '0;
        end

        s1_valid_next  = in_acc ? emit : (s1_move ? 1'b0 : s1_valid_reg);
        s2_valid_next  = s1_move ? 1'b1 : (out_load ? 1'b0 : s2_valid_reg);
        out_valid_next = out_load ? 1'b1 : (res.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dilate_reg    <= bedw_pkg::DILATE_RESET;
            ksize_reg     <= bedw_pkg::KERNEL_RESET;
            iwidth_reg    <= bedw_pkg::WIDTH_RESET;
            iheight_reg   <= bedw_pkg::HEIGHT_RESET;
            settle_reg    <= 1'b1;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_slot_reg   <= '0;
            in_done_reg   <= 1'b0;
            dist_reg      <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_slot_reg  <= '0;
            d_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dilate_reg    <= dilate_next;
            ksize_reg     <= ksize_next;
            iwidth_reg    <= iwidth_next;
            iheight_reg   <= iheight_next;
            settle_reg    <= cfg_acc;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            in_slot_reg   <= in_slot_next;
            in_done_reg   <= in_done_next;
            dist_reg      <= dist_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            out_slot_reg  <= out_slot_next;
            d_reg         <= d_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wm1_reg  <= wm1_next;
        hm1_reg  <= hm1_next;
        half_reg <= half_next;
        lat_reg  <= lat_next;
        if (in_acc)
        begin
            s1_raddr_reg <= win_hi;
            s1_span_reg  <= win_span;
            s1_up_reg    <= win_up;
            s1_dn_reg    <= win_dn;
            s1_slot_reg  <= out_slot_reg;
            s1_last_reg  <= out_last;
        end
        if (s1_move)
        begin
            s2_span_reg <= s1_span_reg;
            s2_up_reg   <= s1_up_reg;
            s2_dn_reg   <= s1_dn_reg;
            s2_slot_reg <= s1_slot_reg;
            s2_last_reg <= s1_last_reg;
        end
        if (out_load)
        begin
            out_value_reg <= (hit == dilate_reg) ? bedw_pkg::PIX_HIGH : bedw_pkg::PIX_LOW;
            out_last_reg  <= s2_last_reg;
        end
    end

    bedw_line_store #(
        .BANKS (BANKS),
        .DEPTH (MAX_WIDTH),
        .WIDTH (DW)
    ) u_line_store (
        .clk   (clk),
        .we    (pix_take),
        .wbank (in_slot_reg),
        .waddr (in_col_reg),
        .wdata (flag_dist),
        .re    (s1_move),
        .raddr (s1_raddr_reg),
        .rdata (bank_dist)
    );

    bedw_window_or #(
        .BANKS (BANKS),
        .DW    (DW),
        .HW    (HW)
    ) u_window_or (
        .run_len (bank_dist),
        .slot    (s2_slot_reg),
        .span    (s2_span_reg),
        .up      (s2_up_reg),
        .dn      (s2_dn_reg),
        .hit     (hit)
    );

    `ASSERT_IMPL(a_backlog_bound, clk, rst_n, !settle_reg, d_reg <= lat_reg)
    `ASSERT_IMPL(a_last_after_input, clk, rst_n, emit && out_last, in_done_reg || (pix_take && in_last))
    `ASSERT_NEXT(a_s2_hold, clk, rst_n, s2_valid_reg && !out_load, s2_valid_reg && $stable(s2_slot_reg))

endmodule

`default_nettype wire
